// File: rtl/core/arlc_pkg.sv
// arlc_pkg: shared types and constants of the ack/retry link controller
// no dependencies
`timescale 1ns / 1ps

package arlc_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    localparam logic [1:0] ACT_RX   = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_SEND = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic       REG_RETRY = 1'b0;
    localparam logic       REG_MAX   = 1'b1;

    // command from controller to datapath
    typedef struct packed {
        logic take;      // accept input item into datapath
        logic dec_load;  // restart the frame generator
        logic dec_step;  // one digit step of converter
        logic emit;      // drive current frame character
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic send_now;  // tick produces a frame
        logic dec_done;  // converter holds all digits
        logic dec_next;  // current character is followed by a decimal field
        logic frame_end; // current character is the newline
    } t_sts;

    function automatic logic [3:0] hex_of(input logic [7:0] c, output logic ok);
        logic [3:0] v;
        ok = 1'b1;
        v  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = c[3:0] + 4'd9;
        else ok = 1'b0;
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? {4'h3, v} : {4'h0, v} + 8'h37;
    endfunction

endpackage

// File: rtl/core/arlc_ctrl.sv
// arlc_ctrl: sequencer for item acceptance and frame emission
// depends on arlc_pkg
`timescale 1ns / 1ps

module arlc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_single,
    output arlc_pkg::t_cmd o_cmd,
    input  arlc_pkg::t_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_CHAR = 5'b00100,
        S_ONE  = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_single    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = i_sts.send_now ? S_LOAD : S_ONE;
                end
            end
            S_ONE: begin
                o_out_valid = 1'b1;
                o_single    = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            S_LOAD: begin
                o_cmd.dec_load = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec_step = 1'b1;
                if (i_sts.dec_done) n_state = S_CHAR;
            end
            S_CHAR: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.frame_end) n_state = S_IDLE;
                    else if (i_sts.dec_next) n_state = S_DEC;
                    else n_state = S_CHAR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// File: rtl/core/arlc_dp.sv
// arlc_dp: link state, ack line parser and frame character generator
// depends on arlc_pkg
`timescale 1ns / 1ps

module arlc_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic [1:0]     i_action,
    input  logic [7:0]     i_rx_byte,
    input  logic [31:0]    i_now_ms,
    input  logic [15:0]    i_msg_seq,
    input  logic [31:0]    i_msg_peak,
    input  logic [15:0]    i_msg_duration_ms,
    input  arlc_pkg::t_cmd i_cmd,
    output arlc_pkg::t_sts o_sts,
    output logic [7:0]     o_char,
    output logic           o_acked,
    output logic           o_pending
);

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_NL     = 8'h0A;

    // configuration
    logic [15:0] r_retry;
    logic [3:0]  r_max;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= 16'd1500;
            r_max   <= 4'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == arlc_pkg::REG_RETRY) r_retry <= i_cfg_data;
            else                                  r_max   <= i_cfg_data[3:0];
        end
    end

    // link and parser state
    logic [arlc_pkg::LEN_W-1:0] r_len;
    logic        r_dol, r_star, r_hend, r_pok, r_dend, r_pend, r_ack;
    logic [7:0]  r_bx, r_hex;
    logic [15:0] r_anum, r_seq, r_dur;
    logic [31:0] r_peak, r_last;
    logic [3:0]  r_cnt;

    logic [31:0] w_el;
    logic        w_elig;
    assign w_el   = i_now_ms - r_last;
    assign w_elig = r_pend && !(r_last != 32'd0 && w_el < {16'd0, r_retry});
    assign o_sts.send_now = (i_action == arlc_pkg::ACT_TICK) && w_elig && (r_cnt < r_max);

    logic [3:0] w_hv;
    logic       w_hok;
    always_comb w_hv = arlc_pkg::hex_of(i_rx_byte, w_hok);

    logic       w_eol, w_digit;
    assign w_eol   = (i_rx_byte == 8'h0A) || (i_rx_byte == 8'h0D);
    assign w_digit = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_dol <= 1'b0; r_star <= 1'b0; r_bx <= '0; r_hex <= '0;
            r_hend <= 1'b0; r_pok <= 1'b0; r_anum <= '0; r_dend <= 1'b0;
            r_pend <= 1'b0; r_ack <= 1'b1; r_seq <= '0; r_peak <= '0; r_dur <= '0;
            r_cnt <= '0; r_last <= '0;
        end else if (i_cmd.take) begin
            unique case (i_action)
                arlc_pkg::ACT_RX: begin
                    if (w_eol) begin
                        if (r_len != '0) begin
                            if (r_dol && r_star && r_pok && r_hex == r_bx && r_anum == r_seq) begin
                                r_ack <= 1'b1; r_pend <= 1'b0;
                            end
                            r_len <= '0; r_dol <= 1'b0; r_star <= 1'b0; r_bx <= '0;
                            r_hex <= '0; r_hend <= 1'b0; r_pok <= 1'b0; r_anum <= '0;
                            r_dend <= 1'b0;
                        end
                    end else if (r_len >= arlc_pkg::LEN_W'(arlc_pkg::LINE_CAPACITY - 1)) begin
                        r_len <= '0; r_dol <= 1'b0; r_star <= 1'b0; r_bx <= '0;
                        r_hex <= '0; r_hend <= 1'b0; r_pok <= 1'b0; r_anum <= '0;
                        r_dend <= 1'b0;
                    end else begin
                        r_len <= r_len + 1'b1;
                        if (r_len == '0) r_dol <= (i_rx_byte == C_DOLLAR);
                        else if (r_star) begin
                            if (!r_hend) begin
                                if (w_hok) r_hex <= {r_hex[3:0], w_hv};
                                else       r_hend <= 1'b1;
                            end
                        end else if (i_rx_byte == C_STAR) begin
                            r_star <= 1'b1;
                            if (r_len <= arlc_pkg::LEN_W'(4)) r_pok <= 1'b0;
                        end else begin
                            r_bx <= r_bx ^ i_rx_byte;
                            if (r_len == arlc_pkg::LEN_W'(1)) r_pok <= (i_rx_byte == 8'h41);
                            else if (r_len == arlc_pkg::LEN_W'(2))
                                r_pok <= r_pok & (i_rx_byte == 8'h43);
                            else if (r_len == arlc_pkg::LEN_W'(3))
                                r_pok <= r_pok & (i_rx_byte == 8'h4B);
                            else if (r_len == arlc_pkg::LEN_W'(4))
                                r_pok <= r_pok & (i_rx_byte == C_COMMA);
                            else if (!r_dend) begin
                                if (w_digit)
                                    r_anum <= 16'((r_anum << 3) + (r_anum << 1)
                                                  + {12'd0, i_rx_byte[3:0]});
                                else r_dend <= 1'b1;
                            end
                        end
                    end
                end
                arlc_pkg::ACT_TICK: begin
                    if (w_elig) begin
                        if (r_cnt >= r_max) r_pend <= 1'b0;
                        else begin
                            r_last <= i_now_ms;
                            r_cnt  <= r_cnt + 4'd1;
                        end
                    end
                end
                arlc_pkg::ACT_SEND: begin
                    r_seq <= i_msg_seq; r_peak <= i_msg_peak; r_dur <= i_msg_duration_ms;
                    r_pend <= 1'b1; r_ack <= 1'b0; r_cnt <= '0; r_last <= '0;
                end
                default: ;
            endcase
        end
    end
    assign o_acked   = r_ack;
    assign o_pending = r_pend;

    // frame generator: phases of the frame
    // 0 "$FALL," (index 0..5) 6 seq 7 ',' 8 peak 9 ',' 10 dur 11 '*' 12 hi 13 lo 14 nl
    logic [3:0]  r_ph;
    logic [2:0]  r_pi;
    logic [31:0] r_dv;
    logic [3:0]  r_dg [10];
    logic [3:0]  r_nd, r_di;
    logic        r_conv;
    logic [7:0]  r_fx;

    logic [7:0] w_c;
    logic       w_decph;
    assign w_decph = (r_ph == 4'd6) || (r_ph == 4'd8) || (r_ph == 4'd10);

    always_comb begin
        case (r_ph)
            4'd0: begin
                case (r_pi)
                    3'd0: w_c = C_DOLLAR;
                    3'd1: w_c = 8'h46;
                    3'd2: w_c = 8'h41;
                    3'd3, 3'd4: w_c = 8'h4C;
                    default: w_c = C_COMMA;
                endcase
            end
            4'd6, 4'd8, 4'd10: w_c = {4'h3, r_dg[r_di]};
            4'd7, 4'd9: w_c = C_COMMA;
            4'd11: w_c = C_STAR;
            4'd12: w_c = arlc_pkg::hex_char(r_fx[7:4]);
            4'd13: w_c = arlc_pkg::hex_char(r_fx[3:0]);
            default: w_c = C_NL;
        endcase
    end
    assign o_char          = w_c;
    assign o_sts.frame_end = (r_ph == 4'd14);
    assign o_sts.dec_done  = !w_decph || !r_conv;
    // the comma before each decimal field starts its conversion
    assign o_sts.dec_next  = (r_ph == 4'd0 && r_pi == 3'd5) || (r_ph == 4'd7) || (r_ph == 4'd9);

    logic [31:0] w_q;
    logic [3:0]  w_r;
    always_comb begin
        w_q = 32'((64'(r_dv) * 64'hCCCCCCCD) >> 35);
        w_r = 4'(r_dv - 32'((w_q << 3) + (w_q << 1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0; r_pi <= '0; r_conv <= 1'b0;
        end else if (i_cmd.dec_load) begin
            r_ph <= '0; r_pi <= '0; r_fx <= '0; r_conv <= 1'b0;
        end else if (i_cmd.dec_step && r_conv) begin
            r_dg[r_nd] <= w_r;
            r_nd <= r_nd + 4'd1;
            r_di <= r_nd;
            r_dv <= w_q;
            if (w_q == 32'd0 || r_nd == 4'd9) r_conv <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_ph != 4'd0 && r_ph < 4'd11) r_fx <= r_fx ^ w_c;
            else if (r_ph == 4'd0 && r_pi != 3'd0) r_fx <= r_fx ^ w_c;
            if (r_ph == 4'd0) begin
                if (r_pi == 3'd5) begin
                    r_ph <= 4'd6; r_dv <= {16'd0, r_seq}; r_nd <= '0; r_conv <= 1'b1;
                end else r_pi <= r_pi + 3'd1;
            end else if (w_decph) begin
                if (r_di != 4'd0) r_di <= r_di - 4'd1;
                else begin
                    r_ph <= r_ph + 4'd1;
                end
            end else begin
                r_ph <= r_ph + 4'd1;
                if (r_ph == 4'd7) begin
                    r_dv <= r_peak; r_nd <= '0; r_conv <= 1'b1;
                end else if (r_ph == 4'd9) begin
                    r_dv <= {16'd0, r_dur}; r_nd <= '0; r_conv <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/ack_retry_link_controller.sv
// ack_retry_link_controller: top level, joins sequencer and datapath
// depends on arlc_pkg, arlc_ctrl, arlc_dp
// a non-sending item is accepted, then gives its single result
// a sending tick is accepted, loads the frame generator, then emits each frame character,
// with a digit-by-digit decimal conversion before each decimal field
// one item at a time; reset is synchronous active low, acked resets to one
`timescale 1ns / 1ps

module ack_retry_link_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte[7:0], now_ms[39:8], msg_seq[55:40], msg_peak[87:56], msg_duration_ms[103:88]
    input  logic [103:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_char[7:0]
    output logic [7:0]  m_axis_tdata,
    // tx_valid[0], acked_flag[1], pending_flag[2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    arlc_pkg::t_cmd w_cmd;
    arlc_pkg::t_sts w_sts;
    logic       w_single, w_acked, w_pend;
    logic [7:0] w_char;

    assign o_cfg_ready = 1'b1;

    arlc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_single(w_single), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    arlc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index[0]), .i_cfg_data(i_cfg_data),
        .i_action(s_axis_tuser), .i_rx_byte(s_axis_tdata[7:0]),
        .i_now_ms(s_axis_tdata[39:8]), .i_msg_seq(s_axis_tdata[55:40]),
        .i_msg_peak(s_axis_tdata[87:56]), .i_msg_duration_ms(s_axis_tdata[103:88]),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_char(w_char),
        .o_acked(w_acked), .o_pending(w_pend)
    );

    // result transfer fields
    assign m_axis_tdata = w_single ? 8'd0 : w_char;
    assign m_axis_tuser = {w_pend, w_acked, !w_single};
    assign m_axis_tlast = w_single || w_sts.frame_end;

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for ack_retry_link_controller, ack parser and frame sender
// depends on arlc_pkg and the rtl of the block; predicts every result and compares it
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic       txv;
        logic [7:0] ch;
        logic       last;
        logic       ack;
        logic       pend;
    } t_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [0:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    ack_retry_link_controller i_dut (.*);

    // clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // model state of the link controller
    logic [15:0] m_retry;
    logic [3:0]  m_max;
    logic [4:0]  m_len;
    logic        m_dollar, m_star, m_hex_end, m_prefix, m_dig_end;
    logic [7:0]  m_xor, m_hex;
    logic [15:0] m_ackno;
    logic        m_pend, m_acked;
    logic [15:0] m_seq, m_dur;
    logic [31:0] m_peak, m_last_t;
    logic [3:0]  m_cnt;

    t_beat       expected_beats[$];
    int          fails, checked, frames_seen, idle_pct;
    bit          quiet;
    longint      cycles;

    task automatic report(input string what, input t_beat got, input t_beat want);
        fails++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic void clear_line();
        m_len = 0; m_dollar = 0; m_star = 0; m_xor = 0; m_hex = 0;
        m_hex_end = 0; m_prefix = 0; m_ackno = 0; m_dig_end = 0;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    // line assembly of received bytes
    function automatic void rx_char(input logic [7:0] c);
        int pos, d;
        if (c == 8'd10 || c == 8'd13) begin
            if (m_len != 0) begin
                if (m_dollar && m_star && m_prefix && m_hex == m_xor && m_ackno == m_seq) begin
                    m_acked = 1; m_pend = 0;
                end
                clear_line();
            end
            return;
        end
        if (m_len >= arlc_pkg::LINE_CAPACITY - 1) begin
            clear_line();
            return;
        end
        pos = m_len;
        m_len++;
        if (pos == 0) begin
            m_dollar = (c == "$");
            return;
        end
        if (m_star) begin
            if (!m_hex_end) begin
                d = hex_digit(c);
                if (d >= 0) m_hex = {m_hex[3:0], d[3:0]};
                else m_hex_end = 1;
            end
            return;
        end
        if (c == "*") begin
            m_star = 1;
            if (pos <= 4) m_prefix = 0;
            return;
        end
        m_xor ^= c;
        if (pos == 1) m_prefix = (c == "A");
        else if (pos == 2) m_prefix &= (c == "C");
        else if (pos == 3) m_prefix &= (c == "K");
        else if (pos == 4) m_prefix &= (c == ",");
        else if (!m_dig_end) begin
            if (c >= "0" && c <= "9") m_ackno = m_ackno * 16'd10 + 16'(c - "0");
            else m_dig_end = 1;
        end
    endfunction

    function automatic void add_decimal(inout logic [7:0] f[$], input logic [31:0] v);
        logic [7:0] t[$];
        do begin
            t.push_front(8'("0" + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (t[i]) f.push_back(t[i]);
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] v);
        return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
    endfunction

    // expected results of one accepted item
    function automatic void predict_link(input logic [1:0] act, input logic [103:0] d);
        logic [7:0] fr[$];
        logic [7:0] x;
        logic [31:0] now;
        t_beat b;
        now = d[39:8];
        if (act == arlc_pkg::ACT_RX) rx_char(d[7:0]);
        else if (act == arlc_pkg::ACT_TICK) begin
            if (m_pend && !(m_last_t != 0 && (now - m_last_t) < {16'd0, m_retry})) begin
                if (m_cnt >= m_max) m_pend = 0;
                else begin
                    fr = '{"$", "F", "A", "L", "L", ","};
                    add_decimal(fr, {16'd0, m_seq});
                    fr.push_back(",");
                    add_decimal(fr, m_peak);
                    fr.push_back(",");
                    add_decimal(fr, {16'd0, m_dur});
                    x = 0;
                    for (int i = 1; i < fr.size(); i++) x ^= fr[i];
                    fr.push_back("*");
                    fr.push_back(hex_ascii(x[7:4]));
                    fr.push_back(hex_ascii(x[3:0]));
                    fr.push_back(8'd10);
                    m_last_t = now;
                    m_cnt++;
                end
            end
        end else if (act == arlc_pkg::ACT_SEND) begin
            m_seq = d[55:40]; m_peak = d[87:56]; m_dur = d[103:88];
            m_pend = 1; m_acked = 0; m_cnt = 0; m_last_t = 0;
        end
        if (fr.size() == 0) begin
            b = '{1'b0, 8'd0, 1'b1, m_acked, m_pend};
            expected_beats.push_back(b);
        end else begin
            foreach (fr[i]) begin
                b = '{1'b1, fr[i], i == fr.size() - 1, m_acked, m_pend};
                expected_beats.push_back(b);
            end
        end
    endfunction

    // send one item, random gaps before it
    task automatic send_item(input logic [1:0] act, input logic [103:0] d);
        @(posedge i_clk);
        while (!quiet && $urandom_range(99) < idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_link(act, d);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic rx_string(input string s);
        for (int i = 0; i < s.len(); i++) send_item(arlc_pkg::ACT_RX, {96'd0, s[i]});
    endtask

    task automatic send_msg(input logic [15:0] seq, input logic [31:0] pk, input logic [15:0] du);
        send_item(arlc_pkg::ACT_SEND, {du, pk, seq, 40'd0});
    endtask

    task automatic tick(input logic [31:0] t);
        send_item(arlc_pkg::ACT_TICK, {64'd0, t, 8'd0});
    endtask

    // well formed ack line, optionally corrupted checksum
    task automatic send_ack(input logic [15:0] n, input bit bad);
        string body;
        logic [7:0] x;
        body = $sformatf("ACK,%0d", n);
        x = 0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        if (bad) x ^= 8'h01;
        rx_string({"$", body, $sformatf("*%02X", x), ($urandom_range(1) ? "\n" : "\r")});
    endtask

    task automatic drain();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == arlc_pkg::REG_RETRY) m_retry = v;
        else m_max = v[3:0];
    endtask

    // result checker and stall generator
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser[0], m_axis_tdata, m_axis_tlast, m_axis_tuser[1],
                        m_axis_tuser[2]};
                if (expected_beats.size() == 0) report("unexpected result", got, got);
                else begin
                    want = expected_beats.pop_front();
                    if (got !== want) report("result fields", got, want);
                    checked++;
                    if (got.txv && got.last) frames_seen++;
                end
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("** ack_retry_link_controller: FAILED **");
            $finish;
        end
    end

    task automatic test_frames();
        tick(32'd100);
        send_msg(16'd0, 32'd0, 16'd0);
        tick(32'd0);
        tick(32'd0);
        send_msg(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        tick(32'd5);
        tick(32'd6);
        tick(32'd1505);
        tick(32'd4);
        send_item(arlc_pkg::ACT_NONE, {104{1'b1}});
    endtask

    task automatic test_acks();
        send_msg(16'd42, 32'd1234, 16'd77);
        tick(32'd10);
        rx_string("\n\r");
        send_ack(16'd41, 1'b0);
        send_ack(16'd42, 1'b1);
        rx_string("$ACX,42*00\n");
        rx_string("$ACK*00\n");
        rx_string({"$ACK,42", 8'd0, "**zz\n"});
        send_ack(16'd42, 1'b0);
        send_ack(16'd7, 1'b0);
        rx_string("$ACK,0123456789012345678901234567890\n");
        rx_string("$ACK,65578*2c\n");
    endtask

    task automatic test_config();
        write_reg(arlc_pkg::REG_RETRY, 16'd0);
        write_reg(arlc_pkg::REG_MAX, 16'd0);
        send_msg(16'd3, 32'd9, 16'd1);
        tick(32'd1);
        tick(32'd2);
        write_reg(arlc_pkg::REG_MAX, 16'd15);
        send_msg(16'd4, 32'd10, 16'd2);
        repeat (3) tick(32'hFFFF_FFF0);
        write_reg(arlc_pkg::REG_RETRY, 16'hFFFF);
        send_msg(16'd5, 32'd11, 16'd3);
        tick(32'hFFFF_FFF0);
        tick(32'h0000_FFE0);
        tick(32'h0001_0000);
        write_reg(arlc_pkg::REG_RETRY, 16'd20);
        write_reg(arlc_pkg::REG_MAX, 16'd3);
    endtask

    task automatic test_random(input int items);
        int n;
        logic [31:0] t;
        n = 0;
        t = $urandom;
        while (n < items) begin
            quiet = (n > items / 2 && n < items / 2 + 30);
            case ($urandom_range(9))
                0, 1: begin
                    send_msg(16'($urandom_range(3)), $urandom, 16'($urandom));
                    n++;
                end
                2, 3, 4: begin
                    t = t + $urandom_range(40);
                    tick(t);
                    n++;
                end
                5, 6: begin
                    send_ack(m_seq ^ 16'($urandom_range(1)), $urandom_range(5) == 0);
                    n += 10;
                end
                7: begin
                    send_item(2'($urandom), {$urandom, $urandom, $urandom, 8'($urandom)});
                    n++;
                end
                default: begin
                    send_item(arlc_pkg::ACT_RX, {96'd0, 8'($urandom)});
                    n++;
                end
            endcase
            if ($urandom_range(39) == 0) drain();
        end
        quiet = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        fails = 0; checked = 0; frames_seen = 0; cycles = 0; idle_pct = 24; quiet = 0;
        m_retry = 16'd1500; m_max = 4'd4; clear_line();
        m_pend = 0; m_acked = 1; m_seq = 0; m_peak = 0; m_dur = 0; m_cnt = 0; m_last_t = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frames();
        test_acks();
        drain();
        test_config();
        test_random(70);
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered frames, ack parsing, retries and config extremes");
        $display("%0d results checked, %0d frames, %0d mismatches", checked, frames_seen, fails);
        if (fails == 0 && expected_beats.size() == 0) $display("** ack_retry_link_controller: PASSED **");
        else $display("** ack_retry_link_controller: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/core/arlc_pkg.sv
rtl/core/arlc_ctrl.sv
rtl/core/arlc_dp.sv
rtl/core/ack_retry_link_controller.sv
sim/tb_top.sv
